/* sv/ilm_pkg.sv */
// ilm_pkg: widths, reset values and helper functions for the iterative log multiplier
// no dependencies; used by iterative_log_multiplier

package ilm_pkg;

  localparam int OPERAND_WIDTH = 8;
  localparam int LEAD_WIDTH    = $clog2(OPERAND_WIDTH);
  localparam int PRODUCT_WIDTH = 16;
  localparam int ITER_WIDTH    = 2;
  localparam int IN_DATA_WIDTH = 2 * OPERAND_WIDTH;

  localparam logic [ITER_WIDTH-1:0] ITER_RESET = ITER_WIDTH'(2);
  localparam int                    ITER_CORR_BIT = 1;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [LEAD_WIDTH-1:0]    lead_t;
  typedef logic [PRODUCT_WIDTH-1:0] product_t;

  // position of the highest set bit, zero for a zero input
  function automatic lead_t lead_one(input operand_t v);
    lead_t pos;
    pos = '0;
    for (int i = 0; i < OPERAND_WIDTH; i++) begin
      if (v[i]) begin
        pos = LEAD_WIDTH'(i);
      end
    end
    return pos;
  endfunction

  // operand with its leading one cleared
  function automatic operand_t residue(input operand_t v);
    operand_t one_hot;
    one_hot = operand_t'(1) << lead_one(v);
    return v ^ one_hot;
  endfunction

  // one approximation step: 2^(kx+ky) + rx*2^ky + ry*2^kx
  function automatic product_t ilm_term(input operand_t x, input operand_t y);
    lead_t                kx;
    lead_t                ky;
    logic [LEAD_WIDTH:0]  ksum;
    product_t             base;
    product_t             part_x;
    product_t             part_y;
    kx     = lead_one(x);
    ky     = lead_one(y);
    ksum   = {1'b0, kx} + {1'b0, ky};
    base   = product_t'(1) << ksum;
    part_x = product_t'(residue(x)) << ky;
    part_y = product_t'(residue(y)) << kx;
    return base + part_x + part_y;
  endfunction

endpackage

/* sv/iterative_log_multiplier.sv */
// iterative_log_multiplier: approximate unsigned 8x8 multiplier, iterative logarithmic scheme
// depends on ilm_pkg for widths and the leading-one and term functions

// Takes one operand pair per cycle while in_tready is high and returns one product per
// request; each request goes through the input register and then the result register.
// The basic term is 2^(ka+kb) plus the shifted residues; with bit 1 of the iterations
// register set and both residues nonzero, a correction term from the two residues is added.
// Products never exceed the exact product and a zero operand gives zero. Write iterations
// only while no request is in flight.

module iterative_log_multiplier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ilm_pkg::ITER_WIDTH-1:0]    cfg_wr_data,   // iterations
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ilm_pkg::IN_DATA_WIDTH-1:0] in_tdata,      // operand_a, operand_b
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ilm_pkg::PRODUCT_WIDTH-1:0] out_tdata      // product
);

  logic [ilm_pkg::ITER_WIDTH-1:0] iterations_r;
  logic                           s1_valid_r;
  ilm_pkg::operand_t              s1_a_r;
  ilm_pkg::operand_t              s1_b_r;
  logic                           out_valid_r;
  ilm_pkg::product_t              product_r;

  logic                           s1_advance;
  ilm_pkg::operand_t              res_a;
  ilm_pkg::operand_t              res_b;
  ilm_pkg::product_t              basic_term;
  ilm_pkg::product_t              corr_term;
  ilm_pkg::product_t              product_nxt;

  assign s1_advance = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_advance;

  always_comb begin
    res_a      = ilm_pkg::residue(s1_a_r);
    res_b      = ilm_pkg::residue(s1_b_r);
    basic_term = ilm_pkg::ilm_term(s1_a_r, s1_b_r);
    corr_term  = '0;
    if (iterations_r[ilm_pkg::ITER_CORR_BIT] && (res_a != '0) && (res_b != '0)) begin
      corr_term = ilm_pkg::ilm_term(res_a, res_b);
    end
    if ((s1_a_r == '0) || (s1_b_r == '0)) begin
      product_nxt = '0;
    end else begin
      product_nxt = basic_term + corr_term;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iterations_r <= ilm_pkg::ITER_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        iterations_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_a_r <= in_tdata[ilm_pkg::OPERAND_WIDTH-1:0];
      s1_b_r <= in_tdata[ilm_pkg::IN_DATA_WIDTH-1:ilm_pkg::OPERAND_WIDTH];
    end
    if (s1_advance && s1_valid_r) begin
      product_r <= product_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = product_r;

`ifndef SYNTHESIS
  a_never_above_exact: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |->
      (product_nxt <= ilm_pkg::product_t'(s1_a_r) * ilm_pkg::product_t'(s1_b_r)))
    else $error("product above exact product");

  a_zero_operand: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && ((s1_a_r == '0) || (s1_b_r == '0))) |-> (product_nxt == '0))
    else $error("zero operand gave nonzero product");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("request taken while pipeline full");

  a_result_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_advance) |=> out_tvalid && (out_tdata == $past(product_nxt)))
    else $error("result register lost a request");
`endif

endmodule

/* dv/tb_iterative_log_multiplier.sv */
// tb_iterative_log_multiplier: self-checking testbench for the iterative log multiplier
// predicts each product from the operands and the iterations setting, checks results in order
// depends on ilm_pkg and iterative_log_multiplier

module tb_iterative_log_multiplier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ilm_pkg::ITER_WIDTH-1:0] ITER_UNUSED_LOW  = ilm_pkg::ITER_WIDTH'(0);
  localparam logic [ilm_pkg::ITER_WIDTH-1:0] ITER_BASIC       = ilm_pkg::ITER_WIDTH'(1);
  localparam logic [ilm_pkg::ITER_WIDTH-1:0] ITER_CORRECTED   = ilm_pkg::ITER_WIDTH'(2);
  localparam logic [ilm_pkg::ITER_WIDTH-1:0] ITER_UNUSED_HIGH = ilm_pkg::ITER_WIDTH'(3);

  typedef struct {
    ilm_pkg::operand_t              a;
    ilm_pkg::operand_t              b;
    logic [ilm_pkg::ITER_WIDTH-1:0] iters;
    ilm_pkg::product_t              product;
  } product_req_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_wr_en;
  logic [ilm_pkg::ITER_WIDTH-1:0]    cfg_wr_data;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [ilm_pkg::IN_DATA_WIDTH-1:0] in_tdata;    // operand_a, operand_b
  logic                              out_tvalid;
  logic                              out_tready;
  logic [ilm_pkg::PRODUCT_WIDTH-1:0] out_tdata;   // product

  product_req_t                   product_q[$];
  logic [ilm_pkg::ITER_WIDTH-1:0] cur_iters;
  bit                             calm;
  int unsigned                    error_count;

  iterative_log_multiplier i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned msb_pos(input int unsigned v);
    int unsigned pos;
    pos = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        pos = i;
      end
    end
    return pos;
  endfunction

  // 2^(kx+ky) plus the shifted residues, residues handed back
  function automatic int unsigned log_term(input int unsigned x, input int unsigned y,
                                           output int unsigned rx, output int unsigned ry);
    int unsigned kx;
    int unsigned ky;
    kx = msb_pos(x);
    ky = msb_pos(y);
    rx = x ^ (32'd1 << kx);
    ry = y ^ (32'd1 << ky);
    return (32'd1 << (kx + ky)) + (rx << ky) + (ry << kx);
  endfunction

  function automatic ilm_pkg::product_t predict_product(input ilm_pkg::operand_t a,
                                                        input ilm_pkg::operand_t b,
                                                        input logic [ilm_pkg::ITER_WIDTH-1:0] iters);
    int unsigned ra;
    int unsigned rb;
    int unsigned sa;
    int unsigned sb;
    int unsigned acc;
    acc = 0;
    if (a != 0 && b != 0) begin
      acc = log_term(32'(a), 32'(b), ra, rb);
      if (iters[ilm_pkg::ITER_CORR_BIT] && ra != 0 && rb != 0) begin
        acc += log_term(ra, rb, sa, sb);
      end
    end
    return ilm_pkg::product_t'(acc);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  function automatic ilm_pkg::operand_t rand_operand();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      return '0;
    end
    if (pick < 20) begin
      return ilm_pkg::operand_t'(1) << $urandom_range(0, ilm_pkg::OPERAND_WIDTH - 1);
    end
    if (pick < 28) begin
      return '1;
    end
    if (pick < 40) begin
      return (ilm_pkg::operand_t'(1) << $urandom_range(0, ilm_pkg::OPERAND_WIDTH - 1)) |
             (ilm_pkg::operand_t'(1) << $urandom_range(0, ilm_pkg::OPERAND_WIDTH - 1));
    end
    return ilm_pkg::operand_t'($urandom);
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic send_request(input ilm_pkg::operand_t a, input ilm_pkg::operand_t b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    product_q.push_back('{a: a, b: b, iters: cur_iters,
                          product: predict_product(a, b, cur_iters)});
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_iterations(input logic [ilm_pkg::ITER_WIDTH-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_iters = value;
  endtask

  // reset setting: zero operands, extremes, zero and nonzero residues
  task automatic test_corrected_directed();
    send_request(8'd0, 8'd0);
    send_request(8'd0, 8'd255);
    send_request(8'd255, 8'd0);
    send_request(8'd1, 8'd1);
    send_request(8'd255, 8'd255);
    send_request(8'd128, 8'd128);
    send_request(8'd128, 8'd255);
    send_request(8'd255, 8'd128);
    send_request(8'd1, 8'd255);
    send_request(8'd129, 8'd129);
    send_request(8'd3, 8'd5);
    send_request(8'd170, 8'd85);
    send_request(8'd64, 8'd200);
    send_request(8'd7, 8'd7);
  endtask

  task automatic test_basic_directed();
    set_iterations(ITER_BASIC);
    send_request(8'd255, 8'd255);
    send_request(8'd129, 8'd129);
    send_request(8'd128, 8'd200);
    send_request(8'd0, 8'd17);
  endtask

  task automatic test_unused_codes();
    set_iterations(ITER_UNUSED_LOW);
    send_request(8'd255, 8'd255);
    send_request(8'd200, 8'd100);
    set_iterations(ITER_UNUSED_HIGH);
    send_request(8'd255, 8'd255);
    send_request(8'd200, 8'd100);
  endtask

  task automatic test_random_phase(input logic [ilm_pkg::ITER_WIDTH-1:0] iters,
                                   input int count);
    set_iterations(iters);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      send_request(rand_operand(), rand_operand());
    end
    calm = 1'b0;
  endtask

  // output stalls
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    product_req_t req;
    if (rst_n && out_tvalid && out_tready) begin
      if (product_q.size() == 0) begin
        report_mismatch($sformatf("product %0h with no request pending", out_tdata));
      end else begin
        req = product_q.pop_front();
        if (out_tdata !== req.product) begin
          report_mismatch($sformatf("a=%0d b=%0d iterations=%0d: product %0h, expected %0h",
                                    req.a, req.b, req.iters, out_tdata, req.product));
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    calm        = 1'b0;
    error_count = 0;
    cur_iters   = ilm_pkg::ITER_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_corrected_directed();
    test_basic_directed();
    test_unused_codes();
    test_random_phase(ITER_UNUSED_HIGH, 360);
    test_random_phase(ITER_BASIC, 360);
    test_random_phase(ITER_UNUSED_LOW, 360);
    test_random_phase(ITER_CORRECTED, 370);

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
